// ----- sv/bvbo_pkg.sv -----
// ----------------------------------------------------------------------------
// bvbo_pkg: shared types and constants for the block occupancy unit
// Sizes, register indexes, command word between front and back, and the
// range clamps applied to the configuration registers.
// ----------------------------------------------------------------------------
package bvbo_pkg;

  localparam int MaxSize   = 256;
  localparam int MaxFactor = 16;
  localparam int CountW    = 8;

  localparam int PosW    = $clog2(MaxSize);
  localparam int PhaseW  = $clog2(MaxFactor);
  localparam int FactorW = 5;
  localparam int SizeW   = 9;
  localparam int CoordW  = SizeW + 1;
  localparam int AddrW   = 2 * PosW;
  localparam int LabelW  = 8;
  localparam int ValueW  = 8;
  localparam int AccW    = CountW + 1;
  localparam int PlaneDepth = MaxSize * MaxSize;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = QPtrW + 1;

  localparam logic [CfgIdxW-1:0] RegFactor = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSizeX  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSizeY  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSizeZ  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFill   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStep   = 3'd5;

  localparam logic [FactorW-1:0] FactorRst = 5'd6;
  localparam logic [SizeW-1:0]   SizeRst   = 9'd256;
  localparam logic [ValueW-1:0]  FillRst   = 8'd0;
  localparam logic [ValueW-1:0]  StepRst   = 8'd1;

  typedef struct packed {
    logic [FactorW-1:0] factor;
    logic [SizeW-1:0]   size_x;
    logic [SizeW-1:0]   size_y;
    logic [SizeW-1:0]   size_z;
    logic [ValueW-1:0]  fill;
    logic [ValueW-1:0]  step;
  } cfg_t;

  // One in-bounds voxel, classified by the front.
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             hit;
    logic             first;
    logic             last_blk;
    logic             last_vol;
  } cmd_t;

  function automatic logic [FactorW-1:0] clamp_factor(input logic [FactorW-1:0] v);
    logic [FactorW-1:0] r;
    r = v;
    if (v == '0) r = FactorW'(1);
    else if (v > FactorW'(MaxFactor)) r = FactorW'(MaxFactor);
    return r;
  endfunction

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > SizeW'(MaxSize)) r = SizeW'(MaxSize);
    return r;
  endfunction

endpackage

// ----- sv/bvbo_if.sv -----
// ----------------------------------------------------------------------------
// bvbo_in_if / bvbo_out_if: valid/ready channels of the occupancy unit
// Input carries one voxel label per word; output carries one block result.
// ----------------------------------------------------------------------------
interface bvbo_in_if;
  logic                         valid;
  logic                         ready;
  logic [bvbo_pkg::LabelW-1:0]  label;

  modport source (output valid, output label, input ready);
  modport sink   (input valid, input label, output ready);
endinterface

interface bvbo_out_if;
  logic                         valid;
  logic                         ready;
  logic [bvbo_pkg::CountW-1:0]  fraction;
  logic                         saturated;
  logic                         last_of_volume;

  modport source (output valid, output fraction, output saturated,
                  output last_of_volume, input ready);
  modport sink   (input valid, input fraction, input saturated,
                  input last_of_volume, output ready);
endinterface

// ----- sv/binary_volume_block_occupancy_unit.sv -----
// ----------------------------------------------------------------------------
// binary_volume_block_occupancy_unit: 3-D box downsampling of a binary volume
// Path to a result: queue write, plane read, then sum into the output register.
// Throughput: one voxel per cycle unless a stalled result holds the back,
//   set by the single read-modify-write port of the accumulator plane,
//   with forwarding for back-to-back same blocks.
// Reset: scan restarts at the first voxel, registers take their reset
//   values; the plane is not cleared, since a block's first voxel loads it.
// ----------------------------------------------------------------------------
module binary_volume_block_occupancy_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bvbo_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bvbo_pkg::CfgDataW-1:0] cfg_data_i,
  bvbo_in_if.sink                       vox_in,
  bvbo_out_if.source                    blk_out
);

  // Configuration registers. Stored bits are kept as written; range
  // clamping happens where they are used.
  bvbo_pkg::cfg_t cfg_q, cfg_d;

  // Front to queue, queue to back.
  logic           push;
  bvbo_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  bvbo_pkg::cmd_t q_head;

  // Decode one register write. Any write, even to an unused index,
  // restarts the scan (the front sees cfg_we_i directly).
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bvbo_pkg::RegFactor: cfg_d.factor = cfg_data_i[bvbo_pkg::FactorW-1:0];
        bvbo_pkg::RegSizeX:  cfg_d.size_x = cfg_data_i[bvbo_pkg::SizeW-1:0];
        bvbo_pkg::RegSizeY:  cfg_d.size_y = cfg_data_i[bvbo_pkg::SizeW-1:0];
        bvbo_pkg::RegSizeZ:  cfg_d.size_z = cfg_data_i[bvbo_pkg::SizeW-1:0];
        bvbo_pkg::RegFill:   cfg_d.fill   = cfg_data_i[bvbo_pkg::ValueW-1:0];
        bvbo_pkg::RegStep:   cfg_d.step   = cfg_data_i[bvbo_pkg::ValueW-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.factor <= bvbo_pkg::FactorRst;
      cfg_q.size_x <= bvbo_pkg::SizeRst;
      cfg_q.size_y <= bvbo_pkg::SizeRst;
      cfg_q.size_z <= bvbo_pkg::SizeRst;
      cfg_q.fill   <= bvbo_pkg::FillRst;
      cfg_q.step   <= bvbo_pkg::StepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: track the scan, drop voxels of partial edge blocks, and tag
  // block start, block end and volume end.
  bvbo_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .cfg_i     (cfg_q),
    .vox_in    (vox_in),
    .q_full_i  (q_full),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  // Hold commands while the back waits on a stalled result.
  bvbo_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Back: one accumulator update per cycle unless stalled; result on last voxel.
  bvbo_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_head),
    .q_pop_o   (q_pop),
    .blk_out   (blk_out)
  );

endmodule

// ----- sv/bvbo_ram.sv -----
// ----------------------------------------------------------------------------
// bvbo_ram: generic single-write, single-read RAM with registered read
// Read returns the old contents on a same-address write in the same cycle.
// ----------------------------------------------------------------------------
module bvbo_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/bvbo_front.sv -----
// ----------------------------------------------------------------------------
// bvbo_front: raster scan tracker and voxel classifier
// Tracks block index, phase and block start per axis; drops voxels of
// partial edge blocks and queues a command for every other voxel.
// ----------------------------------------------------------------------------
module bvbo_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  bvbo_pkg::cfg_t       cfg_i,
  bvbo_in_if.sink              vox_in,
  input  logic                 q_full_i,
  output logic                 push_o,
  output bvbo_pkg::cmd_t       cmd_o
);

  typedef struct packed {
    logic [bvbo_pkg::PosW-1:0]   pos;
    logic [bvbo_pkg::PhaseW-1:0] phase;
    logic [bvbo_pkg::CoordW-1:0] base;
  } axis_t;

  axis_t col_q, col_d, row_q, row_d, slc_q, slc_d;

  logic [bvbo_pkg::FactorW-1:0] f;
  logic [bvbo_pkg::SizeW-1:0]   sx, sy, sz;
  logic                         accept;
  logic                         col_wrap, row_wrap;
  logic                         col_in, row_in, slc_in;
  logic                         col_end, row_end, slc_end;

  function automatic logic wraps(input axis_t a, input logic [bvbo_pkg::SizeW-1:0] size);
    logic [bvbo_pkg::CoordW-1:0] nxt;
    nxt = a.base + bvbo_pkg::CoordW'(a.phase) + bvbo_pkg::CoordW'(1);
    return nxt >= bvbo_pkg::CoordW'(size);
  endfunction

  function automatic axis_t step_axis(input axis_t a,
                                      input logic [bvbo_pkg::FactorW-1:0] fac,
                                      input logic [bvbo_pkg::SizeW-1:0] size);
    axis_t r;
    r = a;
    if (wraps(a, size)) begin
      r = '0;
    end else if (bvbo_pkg::FactorW'(a.phase) + bvbo_pkg::FactorW'(1) >= fac) begin
      r.phase = '0;
      r.pos   = a.pos + bvbo_pkg::PosW'(1);
      r.base  = a.base + bvbo_pkg::CoordW'(fac);
    end else begin
      r.phase = a.phase + bvbo_pkg::PhaseW'(1);
    end
    return r;
  endfunction

  // Block lies fully inside the volume.
  function automatic logic in_blk(input axis_t a,
                                  input logic [bvbo_pkg::FactorW-1:0] fac,
                                  input logic [bvbo_pkg::SizeW-1:0] size);
    return (a.base + bvbo_pkg::CoordW'(fac)) <= bvbo_pkg::CoordW'(size);
  endfunction

  // No further complete block follows on this axis.
  function automatic logic end_blk(input axis_t a,
                                   input logic [bvbo_pkg::FactorW-1:0] fac,
                                   input logic [bvbo_pkg::SizeW-1:0] size);
    return (a.base + bvbo_pkg::CoordW'(fac) + bvbo_pkg::CoordW'(fac))
           > bvbo_pkg::CoordW'(size);
  endfunction

  function automatic logic ph_last(input axis_t a, input logic [bvbo_pkg::FactorW-1:0] fac);
    return bvbo_pkg::FactorW'(a.phase) + bvbo_pkg::FactorW'(1) == fac;
  endfunction

  assign f  = bvbo_pkg::clamp_factor(cfg_i.factor);
  assign sx = bvbo_pkg::clamp_size(cfg_i.size_x);
  assign sy = bvbo_pkg::clamp_size(cfg_i.size_y);
  assign sz = bvbo_pkg::clamp_size(cfg_i.size_z);

  assign vox_in.ready = ~q_full_i;
  assign accept       = vox_in.valid & ~q_full_i;

  assign col_in  = in_blk(col_q, f, sx);
  assign row_in  = in_blk(row_q, f, sy);
  assign slc_in  = in_blk(slc_q, f, sz);
  assign col_end = end_blk(col_q, f, sx);
  assign row_end = end_blk(row_q, f, sy);
  assign slc_end = end_blk(slc_q, f, sz);

  always_comb begin
    cmd_o.addr     = {row_q.pos, col_q.pos};
    cmd_o.hit      = vox_in.label != '0;
    cmd_o.first    = (col_q.phase == '0) & (row_q.phase == '0) & (slc_q.phase == '0);
    cmd_o.last_blk = ph_last(col_q, f) & ph_last(row_q, f) & ph_last(slc_q, f);
    cmd_o.last_vol = cmd_o.last_blk & col_end & row_end & slc_end;
  end

  assign push_o = accept & col_in & row_in & slc_in;

  assign col_wrap = wraps(col_q, sx);
  assign row_wrap = wraps(row_q, sy);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    slc_d = slc_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
      slc_d = '0;
    end else if (accept) begin
      col_d = step_axis(col_q, f, sx);
      if (col_wrap) begin
        row_d = step_axis(row_q, f, sy);
        if (row_wrap) begin
          slc_d = step_axis(slc_q, f, sz);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      slc_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      slc_q <= slc_d;
    end
  end

endmodule

// ----- sv/bvbo_queue.sv -----
// ----------------------------------------------------------------------------
// bvbo_queue: short command FIFO between front and back
// Decouples voxel intake from accumulator updates and result stalls.
// ----------------------------------------------------------------------------
module bvbo_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bvbo_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output bvbo_pkg::cmd_t head_o
);

  bvbo_pkg::cmd_t              slots_q [bvbo_pkg::QueueDepth];
  logic [bvbo_pkg::QPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [bvbo_pkg::QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == bvbo_pkg::QCntW'(bvbo_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + bvbo_pkg::QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + bvbo_pkg::QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + bvbo_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - bvbo_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- sv/bvbo_back.sv -----
// ----------------------------------------------------------------------------
// bvbo_back: accumulator read-modify-write and result register
// Issues the plane read, adds the step with saturation, writes back, and
// loads the output register on the last voxel of a block.
// ----------------------------------------------------------------------------
module bvbo_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bvbo_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  input  bvbo_pkg::cmd_t q_cmd_i,
  output logic           q_pop_o,
  bvbo_out_if.source     blk_out
);

  logic                           b_valid_q, b_valid_d;
  bvbo_pkg::cmd_t                 b_cmd_q;
  logic                           lw_valid_q;
  logic [bvbo_pkg::AddrW-1:0]     lw_addr_q;
  logic [bvbo_pkg::AccW-1:0]      lw_acc_q;
  logic                           out_valid_q, out_valid_d;
  logic [bvbo_pkg::CountW-1:0]    out_frac_q;
  logic                           out_sat_q, out_lov_q;

  logic [bvbo_pkg::AccW-1:0]      ram_rdata, prev_acc, new_acc;
  logic [bvbo_pkg::CountW-1:0]    base_sum, add_val;
  logic [bvbo_pkg::CountW:0]      sum_wide;
  logic                           base_sat;
  logic                           out_free, b_fire, advance;

  assign out_free = ~out_valid_q | blk_out.ready;
  assign b_fire   = b_valid_q & (~b_cmd_q.last_blk | out_free);
  assign advance  = ~b_valid_q | b_fire;
  assign q_pop_o  = q_valid_i & advance;
  assign b_valid_d = advance ? q_valid_i : b_valid_q;

  bvbo_ram #(
    .Width (bvbo_pkg::AccW),
    .Depth (bvbo_pkg::PlaneDepth)
  ) u_plane (
    .clk_i   (clk_i),
    .we_i    (b_fire),
    .waddr_i (b_cmd_q.addr),
    .wdata_i (new_acc),
    .re_i    (q_pop_o),
    .raddr_i (q_cmd_i.addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    // Forward the latest write: the RAM read may predate it.
    prev_acc = (lw_valid_q && lw_addr_q == b_cmd_q.addr) ? lw_acc_q : ram_rdata;
    if (b_cmd_q.first) begin
      base_sum = bvbo_pkg::CountW'(cfg_i.fill);
      base_sat = 1'b0;
    end else begin
      base_sum = prev_acc[bvbo_pkg::CountW-1:0];
      base_sat = prev_acc[bvbo_pkg::CountW];
    end
    add_val  = b_cmd_q.hit ? bvbo_pkg::CountW'(cfg_i.step) : '0;
    sum_wide = {1'b0, base_sum} + {1'b0, add_val};
    if (sum_wide[bvbo_pkg::CountW]) begin
      new_acc = {1'b1, {bvbo_pkg::CountW{1'b1}}};
    end else begin
      new_acc = {base_sat, sum_wide[bvbo_pkg::CountW-1:0]};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (b_fire && b_cmd_q.last_blk) begin
      out_valid_d = 1'b1;
    end else if (blk_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_cmd_q <= q_cmd_i;
    end
    if (b_fire) begin
      lw_addr_q <= b_cmd_q.addr;
      lw_acc_q  <= new_acc;
    end
    if (b_fire && b_cmd_q.last_blk) begin
      out_frac_q <= new_acc[bvbo_pkg::CountW-1:0];
      out_sat_q  <= new_acc[bvbo_pkg::CountW];
      out_lov_q  <= b_cmd_q.last_vol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      lw_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
      if (b_fire) begin
        lw_valid_q <= 1'b1;
      end
    end
  end

  assign blk_out.valid          = out_valid_q;
  assign blk_out.fraction       = out_frac_q;
  assign blk_out.saturated      = out_sat_q;
  assign blk_out.last_of_volume = out_lov_q;

endmodule

// ----- test/tb_binary_volume_block_occupancy_unit.sv -----
// ----------------------------------------------------------------------------
// tb_binary_volume_block_occupancy_unit: self-checking bench for the unit
// Streams binary voxels into the unit and checks every block word against an
// in-bench model of the raster scan and the accumulator plane. Settings are
// swept between volumes, both channels idle and stall at random, and one long
// output hold-off backs the unit up into its input.
// ----------------------------------------------------------------------------
module tb_binary_volume_block_occupancy_unit;

  // Indexes past the last register: a write there only restarts the scan.
  localparam logic [bvbo_pkg::CfgIdxW-1:0] RegSpareA = 3'd6;
  localparam logic [bvbo_pkg::CfgIdxW-1:0] RegSpareB = 3'd7;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 300;       // long output hold-off
  localparam int unsigned RandomVoxels = 550;
  localparam int unsigned RunLimit     = 4_000_000; // time units
  localparam int unsigned MaxPrinted   = 100;
  localparam int unsigned CountMax     = (1 << bvbo_pkg::CountW) - 1;

  typedef struct packed {
    logic [bvbo_pkg::CountW-1:0] fraction;
    logic                        saturated;
    logic                        last_of_volume;
  } block_word_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [bvbo_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bvbo_pkg::CfgDataW-1:0] cfg_data_i;

  bvbo_in_if  vox_if ();
  bvbo_out_if blk_if ();

  binary_volume_block_occupancy_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .vox_in     (vox_if),
    .blk_out    (blk_if)
  );

  // Voxels waiting for the driver, block words waiting for the unit.
  logic [bvbo_pkg::LabelW-1:0] pending_labels [$];
  block_word_t                 expected_blocks [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_go = 1'b0;
  logic        hold_on;
  int unsigned mismatch_count = 0;

  // Model of the unit: register copy, scan position and accumulator plane.
  bvbo_pkg::cfg_t              shadow_cfg;
  int unsigned                 blk_x, blk_y, blk_z;   // block index on each axis
  int unsigned                 sub_x, sub_y, sub_z;   // offset inside the block
  logic [bvbo_pkg::CountW-1:0] acc_value [bvbo_pkg::PlaneDepth];
  logic                        acc_flag  [bvbo_pkg::PlaneDepth];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Registers hold any 5 or 9 bit value; the datapath clamps to legal range.
  function automatic int unsigned limit_to(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Step one axis of the scan; report a wrap so the next axis can advance.
  function automatic bit wrap_axis(inout int unsigned blk, inout int unsigned sub,
                                   input int unsigned f, input int unsigned extent);
    if (blk * f + sub + 1 >= extent) begin
      blk = 0;
      sub = 0;
      return 1'b1;
    end
    if (sub + 1 >= f) begin
      sub = 0;
      blk = blk + 1;
    end else begin
      sub = sub + 1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned volume_voxels(input bvbo_pkg::cfg_t c);
    return limit_to(c.size_x, bvbo_pkg::MaxSize) * limit_to(c.size_y, bvbo_pkg::MaxSize) *
           limit_to(c.size_z, bvbo_pkg::MaxSize);
  endfunction

  // Fold one accepted voxel into its block; queue the block word when the
  // block's last voxel lands. Voxels of partial edge blocks only move the scan.
  function automatic void accumulate_voxel(input logic [bvbo_pkg::LabelW-1:0] label);
    int unsigned f, sx, sy, sz, nx, ny, nz, addr, sum;
    logic        sat;
    block_word_t word;
    f  = limit_to(shadow_cfg.factor, bvbo_pkg::MaxFactor);
    sx = limit_to(shadow_cfg.size_x, bvbo_pkg::MaxSize);
    sy = limit_to(shadow_cfg.size_y, bvbo_pkg::MaxSize);
    sz = limit_to(shadow_cfg.size_z, bvbo_pkg::MaxSize);
    nx = sx / f;
    ny = sy / f;
    nz = sz / f;
    if (blk_x < nx && blk_y < ny && blk_z < nz) begin
      addr = blk_y * bvbo_pkg::MaxSize + blk_x;
      if (sub_x == 0 && sub_y == 0 && sub_z == 0) begin
        sum = shadow_cfg.fill;
        sat = 1'b0;
      end else begin
        sum = acc_value[addr];
        sat = acc_flag[addr];
      end
      if (label != '0) begin
        sum = sum + shadow_cfg.step;
        if (sum > CountMax) begin
          sum = CountMax;
          sat = 1'b1;
        end
      end
      acc_value[addr] = bvbo_pkg::CountW'(sum);
      acc_flag[addr]  = sat;
      if (sub_x + 1 == f && sub_y + 1 == f && sub_z + 1 == f) begin
        word.fraction       = bvbo_pkg::CountW'(sum);
        word.saturated      = sat;
        word.last_of_volume = (blk_x + 1 == nx && blk_y + 1 == ny && blk_z + 1 == nz);
        expected_blocks.push_back(word);
      end
    end
    if (wrap_axis(blk_x, sub_x, f, sx))
      if (wrap_axis(blk_y, sub_y, f, sy))
        void'(wrap_axis(blk_z, sub_z, f, sz));
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrinted) $display("ERROR: %s", what);
    mismatch_count++;
  endtask

  // Drive one register write at the next edge; any write restarts the scan.
  task automatic write_register(input logic [bvbo_pkg::CfgIdxW-1:0] idx,
                                input logic [bvbo_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      bvbo_pkg::RegFactor: shadow_cfg.factor = data[bvbo_pkg::FactorW-1:0];
      bvbo_pkg::RegSizeX:  shadow_cfg.size_x = data[bvbo_pkg::SizeW-1:0];
      bvbo_pkg::RegSizeY:  shadow_cfg.size_y = data[bvbo_pkg::SizeW-1:0];
      bvbo_pkg::RegSizeZ:  shadow_cfg.size_z = data[bvbo_pkg::SizeW-1:0];
      bvbo_pkg::RegFill:   shadow_cfg.fill   = data[bvbo_pkg::ValueW-1:0];
      bvbo_pkg::RegStep:   shadow_cfg.step   = data[bvbo_pkg::ValueW-1:0];
      default: ;
    endcase
    blk_x = 0;
    blk_y = 0;
    blk_z = 0;
    sub_x = 0;
    sub_y = 0;
    sub_z = 0;
  endtask

  // Write all six registers, with junk in the unused upper data bits, and
  // optionally a write to a spare index on top.
  task automatic apply_setting(input bvbo_pkg::cfg_t c, input bit spare);
    logic [bvbo_pkg::CfgDataW-1:0] junk;
    junk = bvbo_pkg::CfgDataW'($urandom);
    write_register(bvbo_pkg::RegFactor,
                   {junk[bvbo_pkg::CfgDataW-1:bvbo_pkg::FactorW], c.factor});
    write_register(bvbo_pkg::RegSizeX, c.size_x);
    write_register(bvbo_pkg::RegSizeY, c.size_y);
    write_register(bvbo_pkg::RegSizeZ, c.size_z);
    write_register(bvbo_pkg::RegFill,
                   {junk[bvbo_pkg::CfgDataW-1:bvbo_pkg::ValueW], c.fill});
    write_register(bvbo_pkg::RegStep, {junk[bvbo_pkg::ValueW], c.step});
    if (spare) write_register($urandom_range(1) ? RegSpareA : RegSpareB, junk);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic bvbo_pkg::cfg_t make_setting(input int unsigned f, sx, sy, sz,
                                                  fill, step);
    bvbo_pkg::cfg_t c;
    c.factor = bvbo_pkg::FactorW'(f);
    c.size_x = bvbo_pkg::SizeW'(sx);
    c.size_y = bvbo_pkg::SizeW'(sy);
    c.size_z = bvbo_pkg::SizeW'(sz);
    c.fill   = bvbo_pkg::ValueW'(fill);
    c.step   = bvbo_pkg::ValueW'(step);
    return c;
  endfunction

  function automatic logic [bvbo_pkg::SizeW-1:0] random_extent();
    if ($urandom_range(19) == 0) return '0;
    return bvbo_pkg::SizeW'($urandom_range(1, 10));
  endfunction

  // Small volumes with small blocks, now and then a factor out of range.
  function automatic bvbo_pkg::cfg_t random_setting();
    bvbo_pkg::cfg_t c;
    int unsigned    pick;
    c.factor = bvbo_pkg::FactorW'($urandom_range(1, 4));
    pick = $urandom_range(15);
    if (pick == 0) c.factor = '0;
    else if (pick == 1) c.factor = bvbo_pkg::FactorW'($urandom_range(5, 31));
    c.size_x = random_extent();
    c.size_y = random_extent();
    c.size_z = random_extent();
    case ($urandom_range(3))
      0:       c.fill = '0;
      1:       c.fill = '1;
      default: c.fill = bvbo_pkg::ValueW'($urandom);
    endcase
    case ($urandom_range(3))
      0:       c.step = '0;
      1:       c.step = '1;
      2:       c.step = bvbo_pkg::ValueW'($urandom_range(1, 8));
      default: c.step = bvbo_pkg::ValueW'($urandom);
    endcase
    return c;
  endfunction

  // density: percent of voxels that are inside (nonzero).
  task automatic push_voxels(input int unsigned n, input int unsigned density);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(99) < density)
        pending_labels.push_back(bvbo_pkg::LabelW'($urandom_range(1, 255)));
      else
        pending_labels.push_back('0);
    end
  endtask

  // Hold until every voxel went in and every block word came out, and the
  // channels stayed quiet long enough for trailing voxels that cause no word.
  task automatic wait_drained();
    int unsigned quiet;
    quiet = 0;
    while (quiet < SettleCycles) begin
      @(posedge clk_i);
      if (pending_labels.size() != 0 || vox_if.valid || expected_blocks.size() != 0)
        quiet = 0;
      else
        quiet++;
    end
  endtask

  task automatic run_setting(input bvbo_pkg::cfg_t c, input int unsigned n,
                             input int unsigned density);
    wait_drained();
    apply_setting(c, 1'b0);
    push_voxels(n, density);
  endtask

  // Voxel driver: offer the next pending voxel, idle at random, and feed the
  // model with every voxel the unit accepts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vox_if.valid <= 1'b0;
      vox_if.label <= '0;
    end else begin
      if (vox_if.valid && vox_if.ready) accumulate_voxel(vox_if.label);
      if (!vox_if.valid || vox_if.ready) begin
        if (pending_labels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          vox_if.valid <= 1'b1;
          vox_if.label <= pending_labels.pop_front();
        end else begin
          vox_if.valid <= 1'b0;
        end
      end
    end
  end

  // Block monitor: compare each accepted word with the oldest prediction,
  // stall at random and during the long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin : block_monitor
    block_word_t want;
    if (!rst_ni) begin
      blk_if.ready <= 1'b0;
    end else begin
      if (blk_if.valid && blk_if.ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch($sformatf("block word with none pending: fraction %0d",
                                    blk_if.fraction));
        end else begin
          want = expected_blocks.pop_front();
          if (blk_if.fraction !== want.fraction)
            report_mismatch($sformatf("fraction %0d, want %0d",
                                      blk_if.fraction, want.fraction));
          if (blk_if.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, want %b",
                                      blk_if.saturated, want.saturated));
          if (blk_if.last_of_volume !== want.last_of_volume)
            report_mismatch($sformatf("last_of_volume %b, want %b",
                                      blk_if.last_of_volume, want.last_of_volume));
        end
      end
      blk_if.ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here once the stimulus arms it.
  initial begin : recv_hold
    hold_on = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin : watchdog
    #(RunLimit);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    bvbo_pkg::cfg_t c;
    int unsigned    random_done, n, len, density, half;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = bvbo_pkg::RegFactor;
    cfg_data_i    = '0;
    send_idle_pct = 36;
    recv_idle_pct = 36;
    random_done   = 0;
    shadow_cfg = make_setting(bvbo_pkg::FactorRst, bvbo_pkg::SizeRst, bvbo_pkg::SizeRst,
                              bvbo_pkg::SizeRst, bvbo_pkg::FillRst, bvbo_pkg::StepRst);
    blk_x = 0;
    blk_y = 0;
    blk_z = 0;
    sub_x = 0;
    sub_y = 0;
    sub_z = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: blocks of 6 in a full-size volume, so no word comes.
    pending_labels = {8'h00, 8'hFF, 8'h01};

    // One-voxel blocks, fill 0, step 255: a single inside voxel reaches the
    // maximum without saturating; run past the end of volume into the next.
    wait_drained();
    apply_setting(make_setting(1, 2, 2, 1, 0, 255), 1'b0);
    pending_labels = {8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'h02};

    // A spare index restarts the scan mid-volume without touching registers.
    wait_drained();
    write_register(RegSpareA, '1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pending_labels = {8'h40, 8'h00, 8'h20, 8'h10};

    // One 2x2x2 block loaded with 254: the first hit tops out, the second
    // saturates on the block's last voxel.
    wait_drained();
    apply_setting(make_setting(2, 2, 2, 2, 254, 1), 1'b0);
    pending_labels = {8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02};

    // Full-length y and z axes with one-voxel blocks.
    run_setting(make_setting(1, 1, 256, 1, 0, 255), 256, 50);
    run_setting(make_setting(1, 1, 1, 256, 200, 100), 256, 50);
    // Zero factor acts as 1, oversize x as 256, zero sizes as 1; wrap too.
    run_setting(make_setting(0, 511, 0, 0, 7, 3), 261, 50);
    // Every size below the factor: the whole volume yields nothing.
    run_setting(make_setting(16, 4, 3, 2, 1, 1), 24, 50);
    // Partial edge blocks on every axis.
    run_setting(make_setting(3, 7, 5, 4, 10, 20), 140, 40);

    // Back-pressure: keep offering voxels while the output is held off, so
    // the unit fills and stalls its input; then pause until it drains.
    wait_drained();
    apply_setting(make_setting(1, 8, 4, 4, 0, 1), 1'b0);
    send_idle_pct = 0;
    push_voxels(200, 50);
    hold_go = 1'b1;
    wait_drained();
    push_voxels(50, 50);

    // Random settings with whole volumes of random voxels; now and then keep
    // the setting, stop mid-volume, or pause the sender until it drains.
    while (random_done < RandomVoxels) begin
      if ($urandom_range(4) == 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 36;
        recv_idle_pct = 36;
      end
      if ($urandom_range(4) != 0) begin
        c = random_setting();
        wait_drained();
        apply_setting(c, $urandom_range(5) == 0);
      end
      len = volume_voxels(shadow_cfg);
      n = len * $urandom_range(1, 2);
      if ($urandom_range(3) == 0) n += $urandom_range(0, len - 1);
      if (n > RandomVoxels - random_done) n = RandomVoxels - random_done;
      density = $urandom_range(0, 100);
      if ($urandom_range(3) == 0) begin
        half = n / 2;
        push_voxels(half, density);
        wait_drained();
        push_voxels(n - half, density);
      end else begin
        push_voxels(n, density);
      end
      random_done += n;
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
